// ----- rtl/uadv_pkg.sv -----
// shared types and constants for the upwind advection stencil
`default_nettype none

package uadv_pkg;

    localparam int DATA_W      = 16;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 6;
    localparam int MAX_COLS_DEF = 32;
    localparam int MIN_SIZE    = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [ROW_W-1:0] GRID_ROWS_RST = 12'd32;
    localparam logic [COL_W-1:0] GRID_COLS_RST = 6'd32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_COEF_X    = 2'd0;
    localparam logic [1:0] REG_COEF_Y    = 2'd1;
    localparam logic [1:0] REG_GRID_ROWS = 2'd2;
    localparam logic [1:0] REG_GRID_COLS = 2'd3;

    // one stencil operation handed to the arithmetic pipeline
    typedef struct packed {
        logic                     interior;
        logic                     last;
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] xp;
        logic signed [DATA_W-1:0] xm;
        logic signed [DATA_W-1:0] yp;
        logic signed [DATA_W-1:0] ym;
    } t_cell_op;

endpackage

`default_nettype wire

// ----- rtl/uadv_ram.sv -----
// generic ram, one write port and two registered read ports
`default_nettype none

module uadv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]                      o_rdata_a,
    output logic      [WIDTH-1:0]                      o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ----- rtl/uadv_alu.sv -----
// four stage upwind arithmetic pipeline with rounding and saturation
`default_nettype none

module uadv_alu
    import uadv_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire t_cell_op                 i_op,
    input  wire logic signed [DATA_W-1:0] i_coef_x,
    input  wire logic signed [DATA_W-1:0] i_coef_y,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_value,
    output logic                          o_last
);

    localparam logic signed [38:0] RndHalf = 39'sd16384;
    localparam logic signed [23:0] SatHi   = 24'sd32767;
    localparam logic signed [23:0] SatLo   = -24'sd32768;

    logic r_v1, r_v2, r_v3, r_v4;
    t_cell_op r_op1;

    // stage 2: differences and coefficient magnitudes
    logic signed [16:0] r_dx, r_dy;
    logic signed [17:0] r_sx, r_sy;
    logic signed [15:0] r_cx, r_cy;
    logic signed [16:0] r_acx, r_acy;
    logic signed [15:0] r_u2;
    logic               r_int2, r_last2;

    // stage 3: products
    logic signed [32:0] r_px, r_py;
    logic signed [34:0] r_ax, r_ay;
    logic signed [15:0] r_u3;
    logic               r_int3, r_last3;

    // stage 4: partial sums
    logic signed [35:0] r_sa, r_sb;
    logic signed [15:0] r_u4;
    logic               r_int4, r_last4;

    logic signed [38:0] acc;
    logic signed [23:0] quo;
    logic signed [15:0] sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op1 <= i_op;

        r_dx    <= 17'(r_op1.xp) - 17'(r_op1.xm);
        r_dy    <= 17'(r_op1.yp) - 17'(r_op1.ym);
        r_sx    <= 18'(r_op1.xp) + 18'(r_op1.xm) - (18'(r_op1.u) <<< 1);
        r_sy    <= 18'(r_op1.yp) + 18'(r_op1.ym) - (18'(r_op1.u) <<< 1);
        r_cx    <= i_coef_x;
        r_cy    <= i_coef_y;
        r_acx   <= i_coef_x[15] ? 17'sd0 - 17'(i_coef_x) : 17'(i_coef_x);
        r_acy   <= i_coef_y[15] ? 17'sd0 - 17'(i_coef_y) : 17'(i_coef_y);
        r_u2    <= r_op1.u;
        r_int2  <= r_op1.interior;
        r_last2 <= r_op1.last;

        r_px    <= 33'(r_cx) * 33'(r_dx);
        r_py    <= 33'(r_cy) * 33'(r_dy);
        r_ax    <= 35'(r_acx) * 35'(r_sx);
        r_ay    <= 35'(r_acy) * 35'(r_sy);
        r_u3    <= r_u2;
        r_int3  <= r_int2;
        r_last3 <= r_last2;

        r_sa    <= 36'(r_ax) - 36'(r_px);
        r_sb    <= 36'(r_ay) - 36'(r_py);
        r_u4    <= r_u3;
        r_int4  <= r_int3;
        r_last4 <= r_last3;
    end

    // round half up at 2^-15, floor, then clamp to 16 bits
    always_comb begin
        acc = (39'(r_u4) <<< 15) + 39'(r_sa) + 39'(r_sb) + RndHalf;
        quo = 24'(acc >>> 15);
        if (quo > SatHi) begin
            sat = 16'sh7FFF;
        end else if (quo < SatLo) begin
            sat = 16'sh8000;
        end else begin
            sat = quo[15:0];
        end
    end

    assign o_valid = r_v4;
    assign o_value = r_int4 ? sat : r_u4;
    assign o_last  = r_last4;

endmodule

`default_nettype wire

// ----- rtl/uadv_out_fifo.sv -----
// small result fifo in flops between the pipeline and the output stream
`default_nettype none

module uadv_out_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_data,
    input  wire logic                         i_pop,
    output logic                              o_valid,
    output logic [WIDTH-1:0]                  o_data,
    output logic [$clog2(DEPTH+1)-1:0]        o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- rtl/upwind_advection_2d_stencil_top.sv -----
// top level of the first order upwind advection stencil, one time step per frame
// path: a result passes the ALU registers and the output fifo on its way to m_axis
// throughput: one cell per cycle while fifo credit is free; the final cell of a frame
//   starts a drain of cols_eff line memory reads during which s_axis_tready is low
// one cycle of s_axis_tready low follows every register write
// reset: synchronous, active low; clears counters, coefficients, sizes to 32;
//   the line memory is not cleared
`default_nettype none

module upwind_advection_2d_stencil_top
    import uadv_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // stream in, tdata: cell_value[15:0]
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,
    // stream out, tdata: new_value[15:0]; tlast: last_of_grid
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [15:0]                m_axis_tdata,
    output logic                       m_axis_tlast,
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [COL_W-1:0] MaxColsW = COL_W'(MAX_COLS);
    localparam logic [COL_W-1:0] MinCols  = COL_W'(MIN_SIZE);
    localparam logic [ROW_W-1:0] MinRows  = ROW_W'(MIN_SIZE);
    localparam logic [CW-1:0]    Credits  = CW'(FIFO_DEPTH);

    // configuration registers
    logic signed [DATA_W-1:0] r_coef_x, r_coef_y;
    logic [ROW_W-1:0]         r_grid_rows;
    logic [COL_W-1:0]         r_grid_cols;
    logic                     r_cfg_hold;   // lets the line memory read settle on new sizes
    logic                     cfg_we;

    // position of the next cell, drain sequencer, west neighbour
    logic [ROW_W-1:0]         r_row, n_row;
    logic [COL_W-1:0]         r_col, n_col;
    logic                     r_drain, n_drain;
    logic [COL_W-1:0]         r_dk, n_dk;
    logic signed [DATA_W-1:0] r_west;
    logic [CW-1:0]            r_credit;     // results in the pipeline plus the fifo

    logic [COL_W-1:0]         cols_eff, cols_m1, c_eff, n_pos;
    logic [ROW_W-1:0]         rows_eff, r_eff;
    logic                     is_final, row_emit, interior, east_ok;
    logic                     credit_ok, in_fire, drain_fire, drain_last, pop;

    // line memory word: above row in the high half, current row in the low half
    logic [2*DATA_W-1:0]      rd_a, rd_b;
    logic [AW-1:0]            rd_addr_a, rd_addr_b;
    logic signed [DATA_W-1:0] ctr, above, east, x_in;

    logic                     alu_valid, alu_out_valid, alu_out_last;
    t_cell_op                 alu_op;
    logic signed [DATA_W-1:0] alu_out_value;
    logic [DATA_W:0]          fifo_data;
    logic [CW-1:0]            fifo_count;

    // ---------------------------------------------------------------
    // register port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_x    <= '0;
            r_coef_y    <= '0;
            r_grid_rows <= GRID_ROWS_RST;
            r_grid_cols <= GRID_COLS_RST;
            r_cfg_hold  <= 1'b0;
        end else begin
            r_cfg_hold <= cfg_we;
            if (cfg_we) begin
                case (paddr[3:2])
                    REG_COEF_X:    r_coef_x    <= pwdata[DATA_W-1:0];
                    REG_COEF_Y:    r_coef_y    <= pwdata[DATA_W-1:0];
                    REG_GRID_ROWS: r_grid_rows <= pwdata[ROW_W-1:0];
                    REG_GRID_COLS: r_grid_cols <= pwdata[COL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COEF_X:    prdata = {{(CFG_DATA_W-DATA_W){r_coef_x[DATA_W-1]}}, r_coef_x};
            REG_COEF_Y:    prdata = {{(CFG_DATA_W-DATA_W){r_coef_y[DATA_W-1]}}, r_coef_y};
            REG_GRID_ROWS: prdata = CFG_DATA_W'(r_grid_rows);
            REG_GRID_COLS: prdata = CFG_DATA_W'(r_grid_cols);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // effective sizes and position, counters past the size act as last
    // ---------------------------------------------------------------
    always_comb begin
        if (r_grid_cols < MinCols) begin
            cols_eff = MinCols;
        end else if (r_grid_cols > MaxColsW) begin
            cols_eff = MaxColsW;
        end else begin
            cols_eff = r_grid_cols;
        end
        rows_eff = (r_grid_rows < MinRows) ? MinRows : r_grid_rows;
    end

    assign cols_m1  = cols_eff - 1'b1;
    assign c_eff    = (r_col >= cols_eff) ? cols_m1 : r_col;
    assign r_eff    = (r_row >= rows_eff) ? rows_eff - 1'b1 : r_row;
    assign is_final = (r_eff == rows_eff - 1'b1) && (c_eff == cols_m1);
    assign row_emit = (r_eff != '0);
    assign east_ok  = (c_eff < cols_m1);
    // the emitted cell sits one row up; interior needs row > 0 and a non-edge column
    assign interior = (r_eff >= ROW_W'(2)) && (c_eff != '0) && east_ok;

    // ---------------------------------------------------------------
    // handshake and credit: every result in flight owns a fifo slot
    // ---------------------------------------------------------------
    assign credit_ok     = (r_credit < Credits);
    assign s_axis_tready = !r_drain && !r_cfg_hold && credit_ok;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign drain_fire    = r_drain && credit_ok;
    assign drain_last    = (r_dk == cols_m1);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign alu_valid     = (in_fire && row_emit) || drain_fire;

    // ---------------------------------------------------------------
    // line memory read data, valid in the cycle of the transaction
    // ---------------------------------------------------------------
    assign x_in  = s_axis_tdata;
    assign ctr   = rd_a[DATA_W-1:0];
    assign above = rd_a[2*DATA_W-1:DATA_W];
    assign east  = east_ok ? rd_b[DATA_W-1:0] : '0;

    always_comb begin
        alu_op          = '0;
        alu_op.u        = ctr;
        if (r_drain) begin
            alu_op.last = drain_last;
        end else begin
            alu_op.interior = interior;
            alu_op.xp       = x_in;
            alu_op.xm       = above;
            alu_op.yp       = east;
            alu_op.ym       = r_west;
        end
    end

    // ---------------------------------------------------------------
    // next position and drain sequencing
    // ---------------------------------------------------------------
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_drain = r_drain;
        n_dk    = r_dk;
        if (in_fire) begin
            if (is_final) begin
                n_row   = '0;
                n_col   = '0;
                n_drain = 1'b1;
                n_dk    = '0;
            end else if (c_eff == cols_m1) begin
                n_col = '0;
                n_row = r_eff + 1'b1;
            end else begin
                n_col = c_eff + 1'b1;
                n_row = r_eff;
            end
        end
        if (drain_fire) begin
            if (drain_last) begin
                n_drain = 1'b0;
            end else begin
                n_dk = r_dk + 1'b1;
            end
        end
    end

    // address the entry the next transaction needs, so its data is ready in time
    assign n_pos     = in_fire ? n_col : c_eff;
    assign rd_addr_a = n_drain ? n_dk[AW-1:0] : n_pos[AW-1:0];
    assign rd_addr_b = rd_addr_a + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_drain  <= 1'b0;
            r_dk     <= '0;
            r_west   <= '0;
            r_credit <= '0;
        end else begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_drain  <= n_drain;
            r_dk     <= n_dk;
            r_credit <= r_credit + CW'(alu_valid) - CW'(pop);
            if (in_fire && row_emit) begin
                r_west <= ctr;
            end
        end
    end

    // ---------------------------------------------------------------
    // line memory: current row moves up, the new cell takes its place
    // ---------------------------------------------------------------
    uadv_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (in_fire),
        .i_waddr   (c_eff[AW-1:0]),
        .i_wdata   ({ctr, x_in}),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    uadv_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (alu_valid),
        .i_op     (alu_op),
        .i_coef_x (r_coef_x),
        .i_coef_y (r_coef_y),
        .o_valid  (alu_out_valid),
        .o_value  (alu_out_value),
        .o_last   (alu_out_last)
    );

    uadv_out_fifo #(
        .WIDTH (DATA_W + 1),
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (alu_out_valid),
        .i_data  ({alu_out_last, alu_out_value}),
        .i_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_data  (fifo_data),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = fifo_data[DATA_W-1:0];
    assign m_axis_tlast = fifo_data[DATA_W];

`ifndef SYNTH
    // credit never exceeds the fifo depth
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= Credits)
        else $error("credit count above fifo depth");

    // the fifo never holds more than the credit accounts for
    a_fifo_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= r_credit)
        else $error("fifo occupancy exceeds credit");

    // the final cell starts the drain at column zero
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_final) |=> (r_drain && r_dk == '0))
        else $error("drain did not start after final cell");

    // the drain index stays inside the row
    a_drain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_dk < cols_eff))
        else $error("drain index past row end");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_upwind_advection_2d_stencil_top.sv -----
// self-checking testbench for the upwind advection stencil: directed frames, random frames, backpressure
`default_nettype none

module tb_upwind_advection_2d_stencil_top
    import uadv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // one expected output transaction
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } grid_result_t;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // cell stream into the block
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;    // cell_value[15:0]

    // updated cells out of the block
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;          // new_value[15:0]
    logic              m_axis_tlast;          // last_of_grid

    // register port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    upwind_advection_2d_stencil_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow of the block's registers and grid state, updated per accepted transaction
    logic signed [DATA_W-1:0] cx_reg   = '0;
    logic signed [DATA_W-1:0] cy_reg   = '0;
    logic [ROW_W-1:0]         rows_reg = GRID_ROWS_RST;
    logic [COL_W-1:0]         cols_reg = GRID_COLS_RST;
    logic signed [DATA_W-1:0] row_above [MAX_COLS_DEF];   // row r-2
    logic signed [DATA_W-1:0] row_prev  [MAX_COLS_DEF];   // row r-1
    int                       next_row  = 0;
    int                       next_col  = 0;
    int                       west_cell = 0;              // centre of the last emitted cell

    grid_result_t expected_cells[$];
    int           mismatches = 0;
    int           results_seen = 0;

    // idling controls shared by the driver and the receiver
    int sender_idle_pct = 0;
    int rx_stall_pct    = 0;
    int rx_hold_req     = 0;
    int rx_hold_left    = 0;

    // 125 MHz clock
    initial forever #4 i_clk = ~i_clk;

    // hard limit on the whole run
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver: random stalls, or a long hold-off counted here when a test asks for one
    always @(posedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left  = rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // compare every output transaction with the oldest expected cell
    always @(posedge i_clk) begin : check_results
        grid_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_cells.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected result value %h last %b",
                             $realtime, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = expected_cells.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tlast !== want.last) begin
                    if (mismatches < 10)
                        $display("%0t: result %0d expected value %h last %b, got value %h last %b",
                                 $realtime, results_seen, want.value, want.last,
                                 m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    // one interior update: exact sum at 2^-15, round half up, saturate to 16 bits
    function automatic logic signed [DATA_W-1:0] upwind_update(input int u, input int xp,
                                                               input int xm, input int yp,
                                                               input int ym);
        longint cx;
        longint cy;
        longint acc;
        cx  = cx_reg;
        cy  = cy_reg;
        acc = longint'(u) * 32768;
        acc = acc - cx * (xp - xm) + (cx < 0 ? -cx : cx) * (xp - 2 * u + xm)
                  - cy * (yp - ym) + (cy < 0 ? -cy : cy) * (yp - 2 * u + ym);
        acc = (acc + 16384) >>> 15;
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        return 16'(acc);
    endfunction

    // append one expected transaction at the tail of the queue
    function automatic void add_expected(input logic [DATA_W-1:0] value, input logic last);
        grid_result_t item;
        item.value = value;
        item.last  = last;
        expected_cells.insert(expected_cells.size(), item);
    endfunction

    // advance the shadow grid by one accepted cell and queue the cells it releases
    function automatic void advance_grid(input logic signed [DATA_W-1:0] cell_in);
        int cols;
        int rows;
        int c;
        int r;
        int ctr;
        int east;
        int v;
        cols = (cols_reg < MIN_SIZE) ? MIN_SIZE :
               (cols_reg > MAX_COLS_DEF ? MAX_COLS_DEF : int'(cols_reg));
        rows = (rows_reg < MIN_SIZE) ? MIN_SIZE : int'(rows_reg);
        // a counter left past a shrunken size acts as the last row or column
        c = (next_col >= cols) ? cols - 1 : next_col;
        r = (next_row >= rows) ? rows - 1 : next_row;

        // from the second row on, each cell releases the cell above it
        if (r >= 1) begin
            ctr  = row_prev[c];
            east = (c + 1 < cols) ? int'(row_prev[c + 1]) : 0;
            v    = ctr;
            if (r >= 2 && c >= 1 && c + 1 < cols)
                v = upwind_update(ctr, cell_in, row_above[c], east, west_cell);
            add_expected(v[15:0], 1'b0);
            west_cell = ctr;
        end

        row_above[c] = row_prev[c];
        row_prev[c]  = cell_in;

        if (r == rows - 1 && c == cols - 1) begin
            // final cell: the last row drains unchanged
            for (int k = 0; k < cols; k++)
                add_expected(row_prev[k], k == cols - 1);
            next_row = 0;
            next_col = 0;
        end else begin
            c++;
            if (c >= cols) begin
                c = 0;
                r++;
            end
            next_col = c;
            next_row = r % (1 << ROW_W);
        end
    endfunction

    // offer one cell until accepted, then maybe go idle for a while
    task automatic send_cell(input logic [15:0] cell_val);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cell_val;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_grid(cell_val);
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register write: setup phase, access phase until pready, then the bus goes idle
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COEF_X:    cx_reg   = val[DATA_W-1:0];
            REG_COEF_Y:    cy_reg   = val[DATA_W-1:0];
            REG_GRID_ROWS: rows_reg = val[ROW_W-1:0];
            REG_GRID_COLS: cols_reg = val[COL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure_grid(input logic [15:0] cx, input logic [15:0] cy,
                                  input int rows, input int cols);
        write_reg(REG_COEF_X, {16'h0, cx});
        write_reg(REG_COEF_Y, {16'h0, cy});
        write_reg(REG_GRID_ROWS, 32'(rows));
        write_reg(REG_GRID_COLS, 32'(cols));
    endtask

    // drop valid, wait for every expected cell, then cover the pipeline latency
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // cell values: full range, near both extremes, or small smooth values
    function automatic logic [15:0] pick_cell();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'h8000 | 16'($urandom_range(0, 255));
            2:       return 16'h7FFF - 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic feed_cells(input int count);
        repeat (count) send_cell(pick_cell());
    endtask

    // 3x3 frames built from extreme values, both coefficient signs at full scale, then zero coefficients
    task automatic test_extreme_values();
        logic [15:0] pattern [9] = '{16'h8000, 16'h7FFF, 16'h0000,
                                     16'hFFFF, 16'h8000, 16'h7FFF,
                                     16'h0001, 16'h7FFF, 16'h8000};
        configure_grid(16'h7FFF, 16'h8000, 3, 3);
        foreach (pattern[i]) send_cell(pattern[i]);
        wait_idle();
        configure_grid(16'h8000, 16'h7FFF, 3, 3);
        foreach (pattern[i]) send_cell(~pattern[i]);
        wait_idle();
        // zero coefficients leave the interior unchanged
        configure_grid(16'h0000, 16'h0000, 3, 3);
        foreach (pattern[i]) send_cell(pattern[8 - i]);
        wait_idle();
    endtask

    // sizes outside the usable range clamp to 3 and to the line depth
    task automatic test_size_clamps();
        configure_grid(pick_coef(), pick_coef(), 1, 2);
        feed_cells(9);
        wait_idle();
        configure_grid(pick_coef(), pick_coef(), 0, 0);
        feed_cells(9);
        wait_idle();
        configure_grid(pick_coef(), pick_coef(), 2, 63);
        feed_cells(3 * MAX_COLS_DEF);
        wait_idle();
    endtask

    // sizes shrunk below the counters mid-frame: the counters act as the last row or column
    task automatic test_shrink_mid_frame();
        configure_grid(pick_coef(), pick_coef(), 4095, 3);
        feed_cells(5 * 3);
        wait_idle();
        write_reg(REG_GRID_ROWS, 32'd3);
        feed_cells(3);
        wait_idle();

        configure_grid(pick_coef(), pick_coef(), 4, 8);
        feed_cells(8 + 5);
        wait_idle();
        write_reg(REG_GRID_COLS, 32'd4);
        feed_cells(1 + 2 * 4);
        wait_idle();
    endtask

    // random whole frames under one idling setting, new registers per frame
    task automatic test_random_frames(input int idle_pct, input int stall_pct, input int budget);
        int sent;
        int rows;
        int cols;
        sender_idle_pct = idle_pct;
        rx_stall_pct    = stall_pct;
        sent = 0;
        while (sent < budget) begin
            rows = $urandom_range(3, 5);
            cols = $urandom_range(3, 6);
            configure_grid(pick_coef(), pick_coef(), rows, cols);
            feed_cells(rows * cols);
            sent += rows * cols;
            wait_idle();
        end
    endtask

    // long receiver hold-off fills the block, then a sender pause mid-frame
    task automatic test_backpressure();
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        configure_grid(pick_coef(), pick_coef(), 3, 8);
        rx_hold_req = 300;
        feed_cells(3 * 8);
        wait_idle();

        rx_stall_pct = 34;
        configure_grid(pick_coef(), pick_coef(), 5, 6);
        feed_cells(3 * 6);
        wait_idle();
        feed_cells(2 * 6);
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_values();
        test_size_clamps();
        test_shrink_mid_frame();
        test_random_frames(0, 0, 10);
        test_random_frames(64, 0, 10);
        test_random_frames(0, 64, 10);
        test_random_frames(34, 34, 10);
        test_backpressure();
        wait_idle();

        if (mismatches == 0 && expected_cells.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
